/* rtl/icdm_pkg.sv */
// ----------------------------------------------------------------------------
// icdm_pkg
// Shared widths and the CORDIC stage angle table for the inverse disk map.
// ----------------------------------------------------------------------------
package icdm_pkg;

   // CORDIC datapath: the vector is scaled so its magnitude sits near 2^59
   localparam int CORDIC_W   = 64;
   localparam int GUARD_BASE = 60;
   // angle in units of pi/4, Q.30, with room for the +/-4 base and the sum
   localparam int ANG_BITS   = 30;
   localparam int ANG_W      = 36;

   typedef logic signed [CORDIC_W-1:0] cordic_type;
   typedef logic signed [ANG_W-1:0]    angle_type;

   localparam logic [63:0] INV_QPI_Q30 = 64'd1367130552;

   // atan(2^-i) / (pi/4) in Q.30
   function automatic angle_type stage_angle(input int i);
      angle_type a;
      unique case (i)
         0:       a = ANG_W'(64'd1073741824);
         1:       a = ANG_W'(64'd633866812);
         2:       a = ANG_W'(64'd334917815);
         3:       a = ANG_W'(64'd170009512);
         4:       a = ANG_W'(64'd85334663);
         5:       a = ANG_W'(64'd42708931);
         6:       a = ANG_W'(64'd21359677);
         7:       a = ANG_W'(64'd10680490);
         8:       a = ANG_W'(64'd5340327);
         9:       a = ANG_W'(64'd2670173);
         default: a = ANG_W'(INV_QPI_Q30 >> i);
      endcase
      return a;
   endfunction

endpackage

/* rtl/icdm_delay.sv */
// ----------------------------------------------------------------------------
// icdm_delay
// Fixed-length shift line that aligns the angle and radius paths.
// ----------------------------------------------------------------------------
module icdm_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] data_i,
   output logic [WIDTH-1:0] data_o
);

   generate
      if (DEPTH == 0) begin : g_none
         assign data_o = data_i;
      end else begin : g_line
         logic [WIDTH-1:0] tap_ff [0:DEPTH-1];
         always_ff @(posedge clock) begin
            tap_ff[0] <= data_i;
            for (int k = 1; k < DEPTH; k++) begin
               tap_ff[k] <= tap_ff[k-1];
            end
         end
         assign data_o = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule

/* rtl/icdm_div_cell.sv */
// ----------------------------------------------------------------------------
// icdm_div_cell
// One restoring step of the fractional divide p2 / total.
// ----------------------------------------------------------------------------
module icdm_div_cell #(
   parameter int DW = 48,
   parameter int QW = 33
) (
   input  logic          clock,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [QW-1:0] quo_i,
   output logic [DW-1:0] rem_o,
   output logic [DW-1:0] den_o,
   output logic [QW-1:0] quo_o
);

   logic [DW:0]   rem2;
   logic [DW:0]   diff;
   logic          ge;
   logic [DW-1:0] rem_ff, den_ff;
   logic [QW-1:0] quo_ff;

   always_comb begin
      rem2 = {rem_i, 1'b0};
      diff = rem2 - {1'b0, den_i};
      ge   = (rem2 >= {1'b0, den_i});
   end

   always_ff @(posedge clock) begin
      rem_ff <= ge ? diff[DW-1:0] : rem2[DW-1:0];
      den_ff <= den_i;
      quo_ff <= {quo_i[QW-2:0], ge};
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

/* rtl/icdm_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// icdm_sqrt_cell
// One digit of the bitwise integer square root.
// ----------------------------------------------------------------------------
module icdm_sqrt_cell #(
   parameter int SW      = 34,
   parameter int BIT_POS = 32
) (
   input  logic          clock,
   input  logic [SW-1:0] val_i,
   input  logic [SW-1:0] res_i,
   output logic [SW-1:0] val_o,
   output logic [SW-1:0] res_o
);

   localparam logic [SW-1:0] BIT = SW'(1) << BIT_POS;

   logic [SW-1:0] trial;
   logic [SW-1:0] val_ff, res_ff;

   assign trial = res_i + BIT;

   always_ff @(posedge clock) begin
      if (val_i >= trial) begin
         val_ff <= val_i - trial;
         res_ff <= (res_i >> 1) + BIT;
      end else begin
         val_ff <= val_i;
         res_ff <= res_i >> 1;
      end
   end

   assign val_o = val_ff;
   assign res_o = res_ff;

endmodule

/* rtl/icdm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// icdm_cordic_cell
// One vectoring micro-rotation; drives y toward zero and sums the angle.
// ----------------------------------------------------------------------------
module icdm_cordic_cell
   import icdm_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  cordic_type x_i,
   input  cordic_type y_i,
   input  angle_type  z_i,
   input  logic       zero_i,
   output cordic_type x_o,
   output cordic_type y_o,
   output angle_type  z_o,
   output logic       zero_o
);

   localparam angle_type ANGLE = stage_angle(STAGE);

   cordic_type x_ff, y_ff, xs, ys;
   angle_type  z_ff;
   logic       zero_ff;

   assign xs = x_i >>> STAGE;
   assign ys = y_i >>> STAGE;

   always_ff @(posedge clock) begin
      if (!y_i[CORDIC_W-1]) begin
         x_ff <= x_i + ys;
         y_ff <= y_i - xs;
         z_ff <= z_i + ANGLE;
      end else begin
         x_ff <= x_i - ys;
         y_ff <= y_i + xs;
         z_ff <= z_i - ANGLE;
      end
      zero_ff <= zero_i;
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign zero_o = zero_ff;

endmodule

/* rtl/inverse_concentric_disk_map_top.sv */
// ----------------------------------------------------------------------------
// inverse_concentric_disk_map_top
// Direction vector to unit-square point, inverse concentric disk mapping.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_dir_x/y/z and raise start; the request is taken
//   on every edge where start is high, since busy is tied low. One request may
//   enter in every cycle, with no dependence between requests.
//   Result channel: rsp_valid pulses for one cycle with rsp_square_u/v. The
//   receiver cannot stall, so the pipeline never holds.
//   The longer of the radius chain (squares, sums, 2*FRAC_BITS+1 quotient
//   steps, the first of them the integer bit, and FRAC_BITS+1 root cells) and
//   the CORDIC chain sets the depth; the shorter path is padded by a delay
//   line, and post stages A, B and C follow. Throughput is one request per cycle.
//   Reset clears the valid line only; requests in flight are dropped.
//   Zero x and y yield 0.5 on both outputs whatever z is.
// ----------------------------------------------------------------------------
module inverse_concentric_disk_map_top
   import icdm_pkg::*;
#(
   parameter int COORD_WIDTH   = 24,
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   output logic                          rsp_valid,
   output logic [FRAC_BITS:0]            rsp_square_u,
   output logic [FRAC_BITS:0]            rsp_square_v
);

   localparam int W      = COORD_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int DW     = 2 * W;            // squares and sums
   localparam int QW     = 2 * F + 1;        // quotient, Q.2F
   localparam int SW     = 2 * F + 2;        // root working width
   localparam int DIVN   = 2 * F;
   localparam int SQRTN  = F + 1;
   localparam int LR     = 3 + DIVN + SQRTN;
   localparam int LC     = 1 + CORDIC_STAGES;
   localparam int DT     = (LR > LC) ? LR - LC : 0;
   localparam int DR     = (LC > LR) ? LC - LR : 0;
   localparam int LAT    = ((LR > LC) ? LR : LC) + 3;
   localparam int GUARD  = GUARD_BASE - W;
   localparam int RW     = F + 2;            // signed radius
   localparam int PW     = RW + ANG_W;       // product width
   localparam int OW     = PW + 2;           // rounding width

   localparam angle_type ONE   = ANG_W'(64'd1) << ANG_BITS;
   localparam angle_type FOUR  = ANG_W'(64'd4) << ANG_BITS;
   localparam angle_type THREE = ANG_W'(64'd3) << ANG_BITS;
   localparam angle_type TWO   = ANG_W'(64'd2) << ANG_BITS;
   localparam logic [F:0] UNIT = (F+1)'(1) << F;
   localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

   // Never stall: every cycle accepts a request.
   assign busy = 1'b0;

   // ---------------- valid line ----------------
   logic [LAT-1:0] valid_ff, valid_in;
   assign valid_in = {valid_ff[LAT-2:0], start & ~busy};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- stage 1: squares and CORDIC prep ----------------
   logic [W-1:0]  ax, ay, az;
   logic [DW-1:0] sqx_ff, sqy_ff, sqz_ff;
   cordic_type    sx, sy, cx_ff, cy_ff;
   angle_type     base_ff;
   logic          zero_ff;

   always_comb begin
      ax = req_dir_x[W-1] ? W'(-req_dir_x) : W'(req_dir_x);
      ay = req_dir_y[W-1] ? W'(-req_dir_y) : W'(req_dir_y);
      az = req_dir_z[W-1] ? W'(-req_dir_z) : W'(req_dir_z);
      sx = cordic_type'({{(CORDIC_W-W){req_dir_x[W-1]}}, req_dir_x}) <<< GUARD;
      sy = cordic_type'({{(CORDIC_W-W){req_dir_y[W-1]}}, req_dir_y}) <<< GUARD;
   end

   always_ff @(posedge clock) begin
      sqx_ff  <= DW'(ax) * DW'(ax);
      sqy_ff  <= DW'(ay) * DW'(ay);
      sqz_ff  <= DW'(az) * DW'(az);
      zero_ff <= (req_dir_x == '0) && (req_dir_y == '0);
      // Turn a left-half vector by pi before the vectoring stages.
      if (req_dir_x[W-1]) begin
         cx_ff   <= -sx;
         cy_ff   <= -sy;
         base_ff <= req_dir_y[W-1] ? -FOUR : FOUR;
      end else begin
         cx_ff   <= sx;
         cy_ff   <= sy;
         base_ff <= '0;
      end
   end

   // ---------------- stage 2: in-plane and full length sums ----------------
   logic [DW-1:0] p2_ff, tot_ff;
   always_ff @(posedge clock) begin
      p2_ff  <= sqx_ff + sqy_ff;
      tot_ff <= sqx_ff + sqy_ff + sqz_ff;
   end

   // ---------------- stage 3: integer quotient bit ----------------
   logic [DW-1:0] rem0_ff, den0_ff;
   logic [QW-1:0] quo0_ff;
   always_ff @(posedge clock) begin
      den0_ff <= tot_ff;
      if (p2_ff >= tot_ff) begin
         rem0_ff <= p2_ff - tot_ff;
         quo0_ff <= QW'(1);
      end else begin
         rem0_ff <= p2_ff;
         quo0_ff <= '0;
      end
   end

   // ---------------- divide chain ----------------
   logic [DW-1:0] div_rem [0:DIVN];
   logic [DW-1:0] div_den [0:DIVN];
   logic [QW-1:0] div_quo [0:DIVN];
   assign div_rem[0] = rem0_ff;
   assign div_den[0] = den0_ff;
   assign div_quo[0] = quo0_ff;

   generate
      for (genvar k = 0; k < DIVN; k++) begin : g_div
         icdm_div_cell #(.DW(DW), .QW(QW)) u_cell (
            .clock (clock),
            .rem_i (div_rem[k]),
            .den_i (div_den[k]),
            .quo_i (div_quo[k]),
            .rem_o (div_rem[k+1]),
            .den_o (div_den[k+1]),
            .quo_o (div_quo[k+1])
         );
      end
   endgenerate

   // ---------------- square root chain ----------------
   logic [SW-1:0] sq_val [0:SQRTN];
   logic [SW-1:0] sq_res [0:SQRTN];
   assign sq_val[0] = SW'(div_quo[DIVN]);
   assign sq_res[0] = '0;

   generate
      for (genvar k = 0; k < SQRTN; k++) begin : g_sqrt
         icdm_sqrt_cell #(.SW(SW), .BIT_POS(2 * (F - k))) u_cell (
            .clock (clock),
            .val_i (sq_val[k]),
            .res_i (sq_res[k]),
            .val_o (sq_val[k+1]),
            .res_o (sq_res[k+1])
         );
      end
   endgenerate

   logic [F:0] rq;
   assign rq = (sq_res[SQRTN] > SW'(UNIT)) ? UNIT : sq_res[SQRTN][F:0];

   // ---------------- CORDIC chain ----------------
   cordic_type cor_x [0:CORDIC_STAGES];
   cordic_type cor_y [0:CORDIC_STAGES];
   angle_type  cor_z [0:CORDIC_STAGES];
   logic       cor_zero [0:CORDIC_STAGES];
   assign cor_x[0]    = cx_ff;
   assign cor_y[0]    = cy_ff;
   assign cor_z[0]    = base_ff;
   assign cor_zero[0] = zero_ff;

   generate
      for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
         icdm_cordic_cell #(.STAGE(k)) u_cell (
            .clock  (clock),
            .x_i    (cor_x[k]),
            .y_i    (cor_y[k]),
            .z_i    (cor_z[k]),
            .zero_i (cor_zero[k]),
            .x_o    (cor_x[k+1]),
            .y_o    (cor_y[k+1]),
            .z_o    (cor_z[k+1]),
            .zero_o (cor_zero[k+1])
         );
      end
   endgenerate

   // ---------------- path alignment ----------------
   logic [ANG_W:0] ang_d;
   logic [F:0]     rad_d;
   angle_type      t_al;
   logic           zero_al;

   icdm_delay #(.WIDTH(ANG_W + 1), .DEPTH(DT)) u_ang_delay (
      .clock  (clock),
      .data_i ({cor_zero[CORDIC_STAGES], cor_z[CORDIC_STAGES]}),
      .data_o (ang_d)
   );

   icdm_delay #(.WIDTH(F + 1), .DEPTH(DR)) u_rad_delay (
      .clock  (clock),
      .data_i (rq),
      .data_o (rad_d)
   );

   assign zero_al = ang_d[ANG_W];
   assign t_al    = angle_type'(ang_d[ANG_W-1:0]);

   // ---------------- post A: wrap and wedge select ----------------
   angle_type            t_wrap;
   logic                 neg;
   logic signed [RW-1:0] rs_ff;
   angle_type            m_ff;
   logic                 lt_ff, zero_a_ff;

   always_comb begin
      neg    = 1'b0;
      t_wrap = t_al;
      priority if (t_al > THREE) begin
         neg    = 1'b1;
         t_wrap = t_al - FOUR;
      end else if (t_al <= -ONE) begin
         neg    = 1'b1;
         t_wrap = t_al + FOUR;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff     <= neg ? -$signed({1'b0, rad_d}) : $signed({1'b0, rad_d});
      lt_ff     <= (t_wrap < ONE);
      m_ff      <= (t_wrap < ONE) ? t_wrap : TWO - t_wrap;
      zero_a_ff <= zero_al;
   end

   // ---------------- post B: multiply ----------------
   logic signed [PW-1:0] prod, full_one;
   logic signed [PW-1:0] u_ff, v_ff;
   logic                 zero_b_ff;

   assign prod     = PW'(rs_ff) * PW'(m_ff);
   assign full_one = PW'(rs_ff) <<< ANG_BITS;

   always_ff @(posedge clock) begin
      u_ff      <= lt_ff ? full_one : prod;
      v_ff      <= lt_ff ? prod : full_one;
      zero_b_ff <= zero_a_ff;
   end

   // ---------------- post C: shift to [0,1], round, saturate ----------------
   function automatic logic [F:0] to_square(input logic signed [PW-1:0] full);
      logic signed [OW-1:0] sum;
      logic [OW-1:0]        rnd;
      logic [F:0]           o;
      sum = OW'(full) + (OW'(1) <<< (F + ANG_BITS));
      rnd = (OW'(sum) + (OW'(1) << ANG_BITS)) >> (ANG_BITS + 1);
      if (sum < 0) begin
         o = '0;
      end else if (rnd > OW'(UNIT)) begin
         o = UNIT;
      end else begin
         o = rnd[F:0];
      end
      return o;
   endfunction

   logic [F:0] su_ff, sv_ff;
   always_ff @(posedge clock) begin
      su_ff <= zero_b_ff ? HALF : to_square(u_ff);
      sv_ff <= zero_b_ff ? HALF : to_square(v_ff);
   end

   assign rsp_valid    = valid_ff[LAT-1];
   assign rsp_square_u = su_ff;
   assign rsp_square_v = sv_ff;

endmodule

/* test/tb_inverse_concentric_disk_map_top.sv */
// ----------------------------------------------------------------------------
// tb_inverse_concentric_disk_map_top
// Self-checking bench for the inverse concentric disk map. A directed stimulus
// table runs first. It covers the extremes, the zero in-plane case, zero z, the
// axes and the wedge edges. Random directions follow. Results are checked field
// by field against a bit-exact fixed-point model of the radius, the CORDIC angle
// and the wedge mapping, or against the answer typed into a directed row.
// ----------------------------------------------------------------------------
module tb_inverse_concentric_disk_map_top;
   timeunit 1ns;
   timeprecision 1ps;
   import icdm_pkg::*;

   localparam int CW        = 24;
   localparam int FB        = 16;
   localparam int STAGES    = 18;
   localparam int QBITS     = 30;
   localparam int LATENCY   = 3 * FB + 4 + 3;
   localparam int N_RANDOM  = 1450;
   localparam int CYCLE_CAP = 200000;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      bit                   fixed;
      logic [FB:0]          u;
      logic [FB:0]          v;
   } dir_row_type;

   typedef struct {
      logic [FB:0] u;
      logic [FB:0] v;
   } square_pt_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CW-1:0] req_dir_x = '0;
   logic signed [CW-1:0] req_dir_y = '0;
   logic signed [CW-1:0] req_dir_z = '0;
   logic                 rsp_valid;
   logic [FB:0]          rsp_square_u;
   logic [FB:0]          rsp_square_v;

   // side-band for directed rows whose answer is typed in
   bit          row_fixed = 1'b0;
   logic [FB:0] row_u     = '0;
   logic [FB:0] row_v     = '0;

   square_pt_type pending_points[$];
   int            mismatches = 0;
   int            cycles     = 0;
   int            n_checked  = 0;

   always #1 clock = ~clock;

   inverse_concentric_disk_map_top #(
      .COORD_WIDTH(CW), .FRAC_BITS(FB), .CORDIC_STAGES(STAGES)
   ) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_square_u(rsp_square_u), .rsp_square_v(rsp_square_v)
   );

   // --------------------------------------------------------------------------
   // Fixed-point model of the mapping
   // --------------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(input longint unsigned val);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > val) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (val >= res + bitv) begin
            val = val - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint atan_step(input int i);
      longint steps[10] = '{1073741824, 633866812, 334917815, 170009512, 85334663,
                            42708931, 21359677, 10680490, 5340327, 2670173};
      if (i < 10) return steps[i];
      return longint'(64'd1367130552 >> i);
   endfunction

   // atan2(y, x) in units of pi/4, Q.30
   function automatic longint quarter_pi_angle(input longint x, input longint y);
      longint base, acc, xs, ys;
      base = 0;
      acc  = 0;
      if (x < 0) begin
         base = (y >= 0) ? (longint'(4) <<< QBITS) : -(longint'(4) <<< QBITS);
         x = -x;
         y = -y;
      end
      x = x <<< (60 - CW);
      y = y <<< (60 - CW);
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            acc = acc + atan_step(i);
         end else begin
            x = x - ys;
            y = y + xs;
            acc = acc - atan_step(i);
         end
      end
      return base + acc;
   endfunction

   // (value + 1) / 2, round half up, clamp to [0, 1.0]
   function automatic logic [FB:0] to_unit(input longint full);
      longint sum, o;
      sum = full + (longint'(1) <<< (FB + QBITS));
      if (sum < 0) return '0;
      o = (sum + (longint'(1) <<< QBITS)) >>> (QBITS + 1);
      if (o > (longint'(1) <<< FB)) o = longint'(1) <<< FB;
      return o[FB:0];
   endfunction

   function automatic square_pt_type map_direction(input logic signed [CW-1:0] dx,
                                                   input logic signed [CW-1:0] dy,
                                                   input logic signed [CW-1:0] dz);
      longint          x, y, z, r, t, u, v, one;
      longint unsigned p2, total, rq;
      logic [127:0]    quot;
      square_pt_type   pt;
      x   = dx;
      y   = dy;
      z   = dz;
      one = longint'(1) <<< QBITS;
      if (x == 0 && y == 0) begin
         pt.u = (FB+1)'(1) << (FB - 1);
         pt.v = (FB+1)'(1) << (FB - 1);
         return pt;
      end
      p2    = x * x + y * y;
      total = p2 + z * z;
      quot  = ({64'd0, p2} << (2 * FB)) / {64'd0, total};
      rq    = int_sqrt(quot[63:0]);
      if (rq > (64'd1 << FB)) rq = 64'd1 << FB;
      r = rq;
      t = quarter_pi_angle(x, y);
      if (t > 3 * one) begin
         r = -r;
         t = t - 4 * one;
      end else if (t <= -one) begin
         r = -r;
         t = t + 4 * one;
      end
      if (t < one) begin
         u = r * one;
         v = r * t;
      end else begin
         v = r * one;
         u = r * (2 * one - t);
      end
      pt.u = to_unit(u);
      pt.v = to_unit(v);
      return pt;
   endfunction

   // --------------------------------------------------------------------------
   // Acceptance and checking, both sampled on the rising edge
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      square_pt_type want;
      cycles <= cycles + 1;
      if (!reset && start && !busy) begin
         // hold the typed-in answer for fixed rows, else predict
         if (row_fixed) begin
            want.u = row_u;
            want.v = row_v;
         end else begin
            want = map_direction(req_dir_x, req_dir_y, req_dir_z);
         end
         pending_points.push_back(want);
      end
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result u=%0d v=%0d", rsp_square_u, rsp_square_v);
         end else begin
            want = pending_points.pop_front();
            n_checked++;
            if (rsp_square_u !== want.u || rsp_square_v !== want.v) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected u=%0d v=%0d, got u=%0d v=%0d",
                           want.u, want.v, rsp_square_u, rsp_square_v);
            end
         end
      end
   end

   // advance the run to a fail on a hung pipeline
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_inverse_concentric_disk_map_top: done, errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Request driver
   // --------------------------------------------------------------------------
   task automatic send_request(input dir_row_type row);
      start     <= 1'b1;
      req_dir_x <= row.x;
      req_dir_y <= row.y;
      req_dir_z <= row.z;
      row_fixed <= row.fixed;
      row_u     <= row.u;
      row_v     <= row.v;
      // hold until the request is taken
      do @(posedge clock); while (busy);
   endtask

   task automatic maybe_idle(input bit allow);
      int n;
      if (allow && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 7);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_comp(input int mode);
      case (mode)
         0:       return CW'($urandom);
         1:       return CW'($signed($urandom_range(0, 64)) - 32);
         2:       return $urandom_range(0, 1) ? CMAX : CMIN;
         3:       return '0;
         default: return CW'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   dir_row_type directed_rows[] = '{
      '{'0,   '0,   '0,   1'b1, 17'd32768, 17'd32768},
      '{'0,   '0,   CMAX, 1'b1, 17'd32768, 17'd32768},
      '{'0,   '0,   CMIN, 1'b1, 17'd32768, 17'd32768},
      '{CMAX, '0,   '0,   1'b0, '0, '0},
      '{CMIN, '0,   '0,   1'b0, '0, '0},
      '{'0,   CMAX, '0,   1'b0, '0, '0},
      '{'0,   CMIN, '0,   1'b0, '0, '0},
      '{CMAX, CMAX, CMAX, 1'b0, '0, '0},
      '{CMIN, CMIN, CMIN, 1'b0, '0, '0},
      '{CMAX, CMIN, '0,   1'b0, '0, '0},
      '{CMIN, CMAX, '0,   1'b0, '0, '0},
      '{24'sd1, '0, '0,   1'b0, '0, '0},
      '{-24'sd1, '0, '0,  1'b0, '0, '0},
      '{24'sd1, 24'sd1, '0, 1'b0, '0, '0},
      '{-24'sd1, 24'sd1, '0, 1'b0, '0, '0},
      '{-24'sd1, -24'sd1, '0, 1'b0, '0, '0},
      '{24'sd1, -24'sd1, '0, 1'b0, '0, '0},
      '{24'sd1, '0, CMAX, 1'b0, '0, '0},
      '{CMIN, -24'sd1, 24'sd5, 1'b0, '0, '0},
      '{CMIN, 24'sd1, 24'sd5, 1'b0, '0, '0},
      '{24'sd1000, 24'sd2000, -24'sd3000, 1'b0, '0, '0},
      '{24'sd3, CMAX, 24'sd1, 1'b0, '0, '0},
      '{-24'sd7, 24'sd5, '0, 1'b0, '0, '0}
   };

   initial begin
      dir_row_type row;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
         maybe_idle(1'b1);
      end
      // drain the pipeline once before the random stream
      wait_drained();

      for (int k = 0; k < N_RANDOM; k++) begin
         row.x     = rand_comp($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 4));
         row.y     = rand_comp($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 4));
         row.z     = rand_comp($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 4));
         row.fixed = 1'b0;
         row.u     = '0;
         row.v     = '0;
         send_request(row);
         // drop idling in the last stretch to run at full rate
         maybe_idle(k < N_RANDOM - 200);
      end

      wait_drained();
      repeat (LATENCY + 5) @(posedge clock);
      $display("checked %0d results: directed extremes, axes, zero plane, random directions",
               n_checked);
      if (mismatches == 0 && pending_points.size() == 0) begin
         $display("tb_inverse_concentric_disk_map_top: done, clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_inverse_concentric_disk_map_top: done, errors");
      end
      $finish;
   end

endmodule
